### sv/rif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rif_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 64;
  localparam int TIME_BITS = 63;
  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

  typedef enum logic [1:0] {
    VERDICT_NEW    = 2'd0,
    VERDICT_DUP    = 2'd1,
    VERDICT_REPLAY = 2'd2,
    VERDICT_FORGET = 2'd3
  } verdict_t;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_FORGET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/rif_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rif_cell
  import rif_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     shift_in,
  input  wire entry_t     load_in,
  output entry_t          entry
);

  entry_t entry_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.load) begin
      entry_next = load_in;
    end else if (ctrl.shift) begin
      entry_next = shift_in;
    end
  end

  // Only the valid bit needs reset; key and time are never looked at while invalid.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.key   <= entry_next.key;
    entry.stamp <= entry_next.stamp;
  end

endmodule
`default_nettype wire

### sv/replay_id_ring_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Replay filter over a ring of ENTRIES recently seen identifier keys. The entries sit in a
// row of cells that rotates by one place per clock while a request walks the ring, so a
// single key compare and timestamp compare at the head of the row visits every entry over
// one full rotation and edits a matching entry as it passes. A request is taken in ST_IDLE,
// rotates the ring once in ST_WALK, then in ST_FINISH writes a new nonzero checked key at
// the insert pointer and loads the result register once the last result is taken.
// The result waits in that register, so a new request is taken while it waits.
module replay_id_ring_filter
  import rif_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 op,
  input  wire logic [63:0]          id_key,
  input  wire logic [TIME_BITS-1:0] timestamp,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                verdict,
  output logic                      matched
);

  state_t state, state_next;

  logic                 req_op;
  logic [KEY_BITS-1:0]  req_key;
  logic [TIME_BITS-1:0] req_time;
  logic [IDX_BITS-1:0]  step;
  logic [IDX_BITS-1:0]  insert_ptr;
  logic                 found;
  logic                 newer;

  entry_t     cells  [ENTRIES];
  cell_ctrl_t ctrl   [ENTRIES];
  entry_t     head_mod;
  entry_t     new_entry;
  logic       head_hit;
  logic       head_newer;
  logic       do_insert;
  logic       accept;
  logic       finish_go;
  verdict_t   verdict_calc;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign finish_go = (state == ST_FINISH) && (!out_valid || out_ready);

  // Keys are unique among valid entries, so at most one hit is seen per rotation.
  always_comb begin
    head_hit   = (state == ST_WALK) && cells[0].valid && (cells[0].key == req_key)
                 && (req_key != '0) && !found;
    head_newer = (req_time > cells[0].stamp);
    head_mod   = cells[0];
    if (head_hit) begin
      if (req_op == OP_FORGET) begin
        head_mod = '0;
      end else if (head_newer) begin
        head_mod.stamp = req_time;
      end
    end
  end

  assign do_insert = finish_go && (req_op == OP_CHECK) && (req_key != '0) && !found;
  assign new_entry = '{valid: 1'b1, key: req_key, stamp: req_time};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t shift_src;
    if (i == ENTRIES - 1) begin : g_tail
      assign shift_src = head_mod;
    end else begin : g_mid
      assign shift_src = cells[i+1];
    end
    assign ctrl[i].shift = (state == ST_WALK);
    assign ctrl[i].load  = do_insert && (insert_ptr == IDX_BITS'(i));
    rif_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .shift_in (shift_src),
      .load_in  (new_entry),
      .entry    (cells[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (req_op == OP_FORGET) begin
      verdict_calc = VERDICT_FORGET;
    end else if (found) begin
      verdict_calc = newer ? VERDICT_DUP : VERDICT_REPLAY;
    end else begin
      verdict_calc = VERDICT_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      insert_ptr <= '0;
      found      <= 1'b0;
      newer      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        found <= 1'b0;
        newer <= 1'b0;
      end else if (head_hit) begin
        found <= 1'b1;
        newer <= head_newer;
      end
      if (state == ST_WALK) begin
        step <= (step == LAST_IDX) ? '0 : step + 1'b1;
      end
      if (do_insert) begin
        insert_ptr <= (insert_ptr == LAST_IDX) ? '0 : insert_ptr + 1'b1;
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= op;
      req_key  <= id_key[KEY_BITS-1:0];
      req_time <= timestamp;
    end
    if (finish_go) begin
      verdict <= verdict_calc;
      matched <= found;
    end
  end

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == '0))
    else $error("walk counter not at zero while idle");

  a_hit_recorded: assert property (@(posedge clk) disable iff (rst)
    head_hit |=> found)
    else $error("hit at ring head was not recorded");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  a_ptr_moves_on_insert: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(insert_ptr)) |-> $past(do_insert))
    else $error("insert pointer moved without an insert");

  a_no_accept_mid_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !in_ready)
    else $error("request taken during a ring walk");

endmodule
`default_nettype wire

### test/replay_id_ring_filter_tb.sv
`timescale 1ns / 1ps
module replay_id_ring_filter_tb
  import rif_pkg::*;
();

  localparam int RANDOM_ITEMS = 1030;
  localparam int POOL_MAX     = 32;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam logic [TIME_BITS-1:0] STAMP_MAX = {TIME_BITS{1'b1}};

  // Mirror of the ring: the verdict expected for every accepted request.
  class verdict_board;
    logic                 slot_used[ENTRIES];
    logic [KEY_BITS-1:0]  slot_key[ENTRIES];
    logic [TIME_BITS-1:0] slot_stamp[ENTRIES];
    int unsigned          next_slot;
    verdict_t             want_verdict[$];
    logic                 want_matched[$];
    int                   mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_stamp[i] = '0;
      end
      next_slot  = 0;
      mismatches = 0;
    endfunction

    function int find_key(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    function void note_request(op_t o, logic [63:0] key_in, logic [TIME_BITS-1:0] t);
      logic [KEY_BITS-1:0] k;
      int                  hit;
      verdict_t            v;
      logic                m;
      k   = key_in[KEY_BITS-1:0];
      m   = 1'b0;
      hit = (k != '0) ? find_key(k) : -1;
      if (o == OP_FORGET) begin
        v = VERDICT_FORGET;
        if (hit >= 0) begin
          slot_used[hit]  = 1'b0;
          slot_key[hit]   = '0;
          slot_stamp[hit] = '0;
          m = 1'b1;
        end
      end else if (k == '0) begin
        v = VERDICT_NEW;
      end else if (hit >= 0) begin
        m = 1'b1;
        if (t > slot_stamp[hit]) begin
          slot_stamp[hit] = t;
          v = VERDICT_DUP;
        end else begin
          v = VERDICT_REPLAY;
        end
      end else begin
        slot_used[next_slot]  = 1'b1;
        slot_key[next_slot]   = k;
        slot_stamp[next_slot] = t;
        next_slot = (next_slot + 1) % ENTRIES;
        v = VERDICT_NEW;
      end
      want_verdict.push_back(v);
      want_matched.push_back(m);
    endfunction

    function void check_result(logic [1:0] v, logic m);
      verdict_t ev;
      logic     em;
      if (want_verdict.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d matched %0d", v, m);
        return;
      end
      ev = want_verdict.pop_front();
      em = want_matched.pop_front();
      if (v !== ev || m !== em) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected verdict %0d matched %0d, got verdict %0d matched %0d",
                   $realtime, ev, em, v, m);
      end
    endfunction

    function int pending();
      return want_verdict.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic [63:0]          id_key;
  logic [TIME_BITS-1:0] timestamp;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           verdict;
  logic                 matched;

  verdict_board         board;
  int                   cycle_count = 0;
  int                   tx_quiet = 0;
  int                   rx_quiet = 0;
  logic [63:0]          pool_key[POOL_MAX];
  logic [TIME_BITS-1:0] pool_stamp[POOL_MAX];
  int                   pool_size;

  replay_id_ring_filter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .id_key    (id_key),
    .timestamp (timestamp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict),
    .matched   (matched)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_request(op_t'(op), id_key, timestamp);
      if (out_valid && out_ready) board.check_result(verdict, matched);
    end
  end

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int pick_gap(ref int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 20);
    if (r < 97) return $urandom_range(21, 60);
    return $urandom_range(61, 120);
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input op_t o, input logic [63:0] k,
                              input logic [TIME_BITS-1:0] t);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    id_key    <= k;
    timestamp <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic refill_pool();
    pool_size = $urandom_range(6, 28);
    for (int i = 0; i < POOL_MAX; i++) begin
      pool_key[i] = random_word();
      if (pool_key[i] == '0) pool_key[i] = 64'd1;
      pool_stamp[i] = $urandom_range(0, 1) ? TIME_BITS'(random_word() >> 2)
                                            : TIME_BITS'($urandom_range(0, 1000));
    end
  endtask

  task automatic run_directed();
    send_request(OP_CHECK, 64'd0, '0);           // empty key is new and not stored
    send_request(OP_FORGET, 64'd0, STAMP_MAX);   // empty key on forget
    send_request(OP_FORGET, 64'd1, '0);          // forget of an absent key
    send_request(OP_CHECK, '1, STAMP_MAX);
    send_request(OP_CHECK, '1, STAMP_MAX);       // equal time is a replay
    send_request(OP_CHECK, 64'd1, '0);
    send_request(OP_CHECK, 64'd1, '0);
    send_request(OP_CHECK, 64'd1, 63'd5);        // newer time
    send_request(OP_CHECK, 64'd1, 63'd3);        // older time
    send_request(OP_FORGET, 64'd1, '0);
    send_request(OP_FORGET, 64'd1, '0);
    send_request(OP_CHECK, 64'd1, 63'd2);
    // Fill the ring and wrap over the all-ones key; the all-ones key then returns into the freed slot.
    for (int i = 0; i < 14; i++)
      send_request(OP_CHECK, 64'h8000_0000_0000_0000 | 64'(i + 2), 63'(i));
    send_request(OP_CHECK, '1, '0);
  endtask

  task automatic run_random();
    int                   r;
    int                   pick;
    op_t                  o;
    logic [63:0]          k;
    logic [TIME_BITS-1:0] t;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) refill_pool();
      r    = $urandom_range(0, 99);
      pick = $urandom_range(0, pool_size - 1);
      o    = OP_CHECK;
      k    = pool_key[pick];
      t    = TIME_BITS'(random_word());
      if (r < 5) begin
        k = '0;
        o = op_t'($urandom_range(0, 1));
      end else if (r < 15) begin
        o = OP_FORGET;
        if ($urandom_range(0, 3) == 0) k = random_word();
      end else if (r < 20) begin
        k = random_word();
      end else if (r < 25) begin
        k = k ^ (64'd1 << $urandom_range(0, 63));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: t = pool_stamp[pick] + TIME_BITS'($urandom_range(1, 1000));
          4, 5:       t = pool_stamp[pick];
          6, 7:       t = pool_stamp[pick] - TIME_BITS'($urandom_range(1, 1000));
          default:    t = TIME_BITS'(random_word());
        endcase
        if (t > pool_stamp[pick]) pool_stamp[pick] = t;
      end
      send_request(o, k, t);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int gap;
      gap = pick_gap(rx_quiet);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    board     = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_CHECK;
    id_key    = '0;
    timestamp = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // The last request is noted at the edge that accepted it, so let that edge settle first.
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (4 * ENTRIES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
